// File: hw/rtl/rtspd_pkg.sv
// Shared types and constants of the RTSP interleaved deframer.
package rtspd_pkg;

	// Parser phase; codes above PH_TEXT behave as hunting
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_CHAN    = 3'd1,
		PH_LENHI   = 3'd2,
		PH_LENLO   = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_TEXT    = 3'd5
	} phase_t;

	localparam logic [7:0]  DOLLAR           = 8'h24;
	localparam logic [7:0]  CR               = 8'h0D;
	localparam logic [7:0]  LF               = 8'h0A;
	localparam logic [15:0] MIN_TEXT_LEN     = 16'd4;
	localparam logic [15:0] MAX_TEXT_LEN_RST = 16'd4096;

	// Frame kinds
	localparam logic KIND_BINARY = 1'b0;
	localparam logic KIND_TEXT   = 1'b1;

	// One tagged output byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_kind;
		logic [7:0] channel_id;
		logic       first_byte;
		logic       header_byte;
		logic       last_byte;
		logic       overflow;
	} res_t;

endpackage

// File: hw/rtl/rtspd_in_stage.sv
// Input register stage: holds one byte until the parser takes it.
module rtspd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	input  logic       take
);
	import rtspd_pkg::*;

	// Accept when empty or when the held byte leaves this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// File: hw/rtl/rtspd_parser.sv
// Frame parser: phase state, length and text counters, result tagging.
module rtspd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_value,
	input  logic                step,
	input  logic [7:0]          byte_in,
	output rtspd_pkg::res_t     res
);
	import rtspd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  chan_q, chan_d;
	logic [15:0] left_q, left_d;
	logic [15:0] tcount_q, tcount_d;
	logic [1:0]  term_q, term_d;
	logic [15:0] max_len_q;

	logic        is_hunt;
	logic [15:0] limit;
	logic [15:0] tcount_inc;
	logic [1:0]  term_base;
	logic [1:0]  term_nxt;
	logic        term_done;
	logic        text_cut;
	logic [15:0] len_full;
	logic [15:0] left_dec;

	// Hunting covers the unused phase codes as well
	assign is_hunt = (phase_q != PH_CHAN) && (phase_q != PH_LENHI) &&
	                 (phase_q != PH_LENLO) && (phase_q != PH_PAYLOAD) &&
	                 (phase_q != PH_TEXT);

	// Text counting restarts at the first byte of a frame
	assign limit      = (max_len_q < MIN_TEXT_LEN) ? MIN_TEXT_LEN : max_len_q;
	assign tcount_inc = (is_hunt ? 16'd0 : tcount_q) + 16'd1;
	assign term_base  = is_hunt ? 2'd0 : term_q;
	assign text_cut   = !term_done && (tcount_inc >= limit);
	assign len_full   = {left_q[15:8], byte_in};
	assign left_dec   = left_q - 16'd1;

	// Advance the CR LF CR LF matcher
	always_comb begin
		term_done = 1'b0;
		priority if (term_base == 2'd3 && byte_in == LF) begin
			term_done = 1'b1;
			term_nxt  = 2'd0;
		end else if (term_base == 2'd1 && byte_in == LF) begin
			term_nxt = 2'd2;
		end else if (term_base == 2'd2 && byte_in == CR) begin
			term_nxt = 2'd3;
		end else if (byte_in == CR) begin
			term_nxt = 2'd1;
		end else begin
			term_nxt = 2'd0;
		end
	end

	// Next state
	always_comb begin
		phase_d  = phase_q;
		chan_d   = chan_q;
		left_d   = left_q;
		tcount_d = tcount_q;
		term_d   = term_q;
		unique case (phase_q)
			PH_CHAN: begin
				chan_d  = byte_in;
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				left_d  = {byte_in, 8'd0};
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				left_d  = len_full;
				phase_d = (len_full == 16'd0) ? PH_HUNT : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				left_d  = left_dec;
				phase_d = (left_dec == 16'd0) ? PH_HUNT : PH_PAYLOAD;
			end
			default: begin
				if (is_hunt && byte_in == DOLLAR) begin
					phase_d = PH_CHAN;
				end else begin
					tcount_d = tcount_inc;
					if (term_done || text_cut) begin
						phase_d = PH_HUNT;
						term_d  = 2'd0;
					end else begin
						phase_d = PH_TEXT;
						term_d  = term_nxt;
					end
				end
			end
		endcase
	end

	// Result tags for the current byte
	always_comb begin
		res             = '0;
		res.out_byte    = byte_in;
		res.frame_kind  = KIND_BINARY;
		unique case (phase_q)
			PH_CHAN: begin
				res.channel_id  = byte_in;
				res.header_byte = 1'b1;
			end
			PH_LENHI: begin
				res.channel_id  = chan_q;
				res.header_byte = 1'b1;
			end
			PH_LENLO: begin
				res.channel_id  = chan_q;
				res.header_byte = 1'b1;
				res.last_byte   = (len_full == 16'd0);
			end
			PH_PAYLOAD: begin
				res.channel_id = chan_q;
				res.last_byte  = (left_dec == 16'd0);
			end
			default: begin
				res.first_byte = is_hunt;
				if (is_hunt && byte_in == DOLLAR) begin
					res.header_byte = 1'b1;
				end else begin
					res.frame_kind = KIND_TEXT;
					res.last_byte  = term_done || text_cut;
					res.overflow   = text_cut;
				end
			end
		endcase
	end

	// Hold state; advance on each byte taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			chan_q   <= 8'd0;
			left_q   <= 16'd0;
			tcount_q <= 16'd0;
			term_q   <= 2'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			chan_q   <= chan_d;
			left_q   <= left_d;
			tcount_q <= tcount_d;
			term_q   <= term_d;
		end
	end

	// Text length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_TEXT_LEN_RST;
		end else if (cfg_we) begin
			max_len_q <= cfg_value;
		end
	end

endmodule

// File: hw/rtl/rtspd_out_stage.sv
// Result register stage: holds one tagged byte until the receiver takes it.
module rtspd_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_valid,
	output logic            res_ready,
	input  rtspd_pkg::res_t res,
	output logic            out_valid,
	input  logic            out_ready,
	output rtspd_pkg::res_t res_s2
);
	import rtspd_pkg::*;

	// Load when empty or when the held beat leaves this cycle
	assign res_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_ready) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

// File: hw/rtl/rtsp_interleaved_deframer.sv
// Top level of the RTSP interleaved deframer.
//
// Takes a TCP byte stream on the slave stream (one byte per beat) and sends
// every byte back out on the master stream, tagged with its place in a
// frame: interleaved binary frames ('$', channel, 16-bit big-endian length,
// payload) and text frames ending at CR LF CR LF. A text frame reaching
// max_text_len bytes without a terminator is cut with overflow set.
// The cfg channel writes max_text_len (values below 4 act as 4); it is
// always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this. An accepted byte passes the
// input register and then the result register before it is presented on
// the master side. Throughput: one byte per cycle while the receiver is
// ready, set by the parser update between the input and result registers.
// Reset returns the parser to hunting, clears the counters, empties both
// registers and sets max_text_len to 4096. When the receiver stalls the
// result register holds its beat, the input register takes one more byte
// only if it is empty, and then s_axis_tready falls until the stall clears.
module rtsp_interleaved_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] channel_id
	output logic [3:0]  m_axis_tuser,   // [0] frame_kind, [1] first_byte,
	                                    // [2] header_byte, [3] overflow
	output logic        m_axis_tlast,   // last_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data        // max_text_len
);
	import rtspd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_ready;
	logic       step;
	res_t       res;
	res_t       res_s2;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && res_ready;

	rtspd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.take     (step)
	);

	rtspd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_value (cfg_data),
		.step      (step),
		.byte_in   (byte_s1),
		.res       (res)
	);

	rtspd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (valid_s1),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_s2    (res_s2)
	);

	// Pack the beat
	assign m_axis_tdata = {res_s2.channel_id, res_s2.out_byte};
	assign m_axis_tuser = {res_s2.overflow, res_s2.header_byte,
	                       res_s2.first_byte, res_s2.frame_kind};
	assign m_axis_tlast = res_s2.last_byte;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the RTSP interleaved deframer.
`timescale 1ns / 1ps

module tb;
	import rtspd_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int CALM_LO     = 1500;
	localparam int CALM_HI     = 2300;
	localparam int BYTE_GOAL   = 1850;
	localparam int PRINT_CAP   = 40;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_CFG  = 1'b1
	} stim_op_t;

	typedef struct {
		stim_op_t    op;
		logic [15:0] val;
	} stim_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	stim_t stim_q[$];
	res_t  tag_q[$];

	// Predictor state
	phase_t      ph;
	logic [7:0]  chan_q;
	logic [15:0] left_q;
	logic [15:0] tcount_q;
	logic [1:0]  tprog_q;
	logic [15:0] max_len_q;

	int cyc = 0;
	int n_err = 0;
	int n_queued = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_cfg = 0;
	int n_ovf = 0;
	int n_bin = 0;
	int stall_cnt = 0;

	rtsp_interleaved_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	// Random idling, switched off across one calm window
	function automatic logic take_break();
		if (cyc >= CALM_LO && cyc < CALM_HI)
			return 1'b0;
		return $urandom_range(99) < 31;
	endfunction

	task automatic flag_error(input string msg);
		n_err++;
		if (n_err <= PRINT_CAP)
			$display("tb: mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			flag_error($sformatf("beat %0d %s got %h want %h", n_checked, name, got, want));
	endtask

	// Step the CR LF CR LF matcher and the text length limit
	task automatic text_tally(input logic [7:0] b, inout res_t r);
		logic [15:0] lim;
		logic        done;
		lim = (max_len_q < MIN_TEXT_LEN) ? MIN_TEXT_LEN : max_len_q;
		tcount_q = tcount_q + 16'd1;
		done = 1'b0;
		if (tprog_q == 2'd3 && b == LF) begin
			done = 1'b1;
			tprog_q = 2'd0;
		end else if (tprog_q == 2'd1 && b == LF) begin
			tprog_q = 2'd2;
		end else if (tprog_q == 2'd2 && b == CR) begin
			tprog_q = 2'd3;
		end else if (b == CR) begin
			tprog_q = 2'd1;
		end else begin
			tprog_q = 2'd0;
		end
		if (done) begin
			r.last_byte = 1'b1;
			ph = PH_HUNT;
			tprog_q = 2'd0;
		end else if (tcount_q >= lim) begin
			r.last_byte = 1'b1;
			r.overflow = 1'b1;
			ph = PH_HUNT;
			tprog_q = 2'd0;
		end else begin
			ph = PH_TEXT;
		end
	endtask

	// Tag one stream byte and advance the predictor
	task automatic deframe_byte(input logic [7:0] b, output res_t r);
		r = '0;
		r.out_byte = b;
		r.frame_kind = KIND_BINARY;
		case (ph)
			PH_CHAN: begin
				chan_q = b;
				r.channel_id = b;
				r.header_byte = 1'b1;
				ph = PH_LENHI;
			end
			PH_LENHI: begin
				r.channel_id = chan_q;
				r.header_byte = 1'b1;
				left_q = {b, 8'h00};
				ph = PH_LENLO;
			end
			PH_LENLO: begin
				r.channel_id = chan_q;
				r.header_byte = 1'b1;
				left_q = left_q | {8'h00, b};
				if (left_q == 16'd0) begin
					r.last_byte = 1'b1;
					ph = PH_HUNT;
				end else begin
					ph = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.channel_id = chan_q;
				left_q = left_q - 16'd1;
				if (left_q == 16'd0) begin
					r.last_byte = 1'b1;
					ph = PH_HUNT;
				end
			end
			PH_TEXT: begin
				r.frame_kind = KIND_TEXT;
				text_tally(b, r);
			end
			default: begin
				r.first_byte = 1'b1;
				if (b == DOLLAR) begin
					r.header_byte = 1'b1;
					ph = PH_CHAN;
				end else begin
					r.frame_kind = KIND_TEXT;
					tcount_q = 16'd0;
					tprog_q = 2'd0;
					text_tally(b, r);
				end
			end
		endcase
	endtask

	// Stimulus builders
	task automatic push_byte(input logic [7:0] b);
		stim_t s;
		s.op = OP_BYTE;
		s.val = {8'h00, b};
		stim_q.insert(stim_q.size(), s);
		n_queued++;
	endtask

	task automatic push_cfg(input logic [15:0] v);
		stim_t s;
		s.op = OP_CFG;
		s.val = v;
		stim_q.insert(stim_q.size(), s);
	endtask

	// Bias towards the bytes that steer the parser
	function automatic logic [7:0] rand_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return CR;
		if (pick < 25)
			return LF;
		if (pick < 30)
			return DOLLAR;
		return 8'($urandom_range(255));
	endfunction

	task automatic push_binary(input logic [7:0] chan, input logic [15:0] len);
		push_byte(DOLLAR);
		push_byte(chan);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(255)));
	endtask

	task automatic push_text(input int body_len, input logic terminated);
		logic [7:0] b;
		b = rand_byte();
		if (b == DOLLAR)
			b = 8'h47;
		push_byte(b);
		for (int i = 1; i < body_len; i++)
			push_byte(rand_byte());
		if (terminated) begin
			push_byte(CR);
			push_byte(LF);
			push_byte(CR);
			push_byte(LF);
		end
	endtask

	// Driver: present bytes and register writes from the pending queue
	always @(posedge clk or negedge arst_n) begin : drv_proc
		stim_t head;
		res_t  r;
		logic  quiet;
		logic  nxt_valid;
		logic  nxt_cfg;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			cfg_valid <= 1'b0;
			cfg_data <= 16'h0000;
		end else begin
			// retire accepted beats into the predictor
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata, r);
				tag_q.insert(tag_q.size(), r);
				n_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				max_len_q = cfg_data;
				n_cfg++;
			end
			quiet = (tag_q.size() == 0);
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the byte beat
			end else if (cfg_valid && !cfg_ready) begin
				// hold the register write
			end else begin
				nxt_valid = 1'b0;
				nxt_cfg = 1'b0;
				if (stim_q.size() != 0) begin
					head = stim_q[0];
					case (head.op)
						OP_BYTE: begin
							if (!take_break()) begin
								s_axis_tdata <= head.val[7:0];
								nxt_valid = 1'b1;
								void'(stim_q.pop_front());
							end
						end
						OP_CFG: begin
							// write only once every tagged byte has come back
							if (quiet) begin
								cfg_data <= head.val;
								nxt_cfg = 1'b1;
								void'(stim_q.pop_front());
							end
						end
						default: begin
							void'(stim_q.pop_front());
						end
					endcase
				end
				s_axis_tvalid <= nxt_valid;
				cfg_valid <= nxt_cfg;
			end
		end
	end

	// Monitor: compare each tagged byte with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : mon_proc
		res_t got;
		res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.out_byte = m_axis_tdata[7:0];
				got.channel_id = m_axis_tdata[15:8];
				got.frame_kind = m_axis_tuser[0];
				got.first_byte = m_axis_tuser[1];
				got.header_byte = m_axis_tuser[2];
				got.overflow = m_axis_tuser[3];
				got.last_byte = m_axis_tlast;
				if (tag_q.size() == 0) begin
					flag_error($sformatf("unexpected beat, byte %h", got.out_byte));
				end else begin
					want = tag_q.pop_front();
					check_field("out_byte", 16'(got.out_byte), 16'(want.out_byte));
					check_field("frame_kind", 16'(got.frame_kind), 16'(want.frame_kind));
					check_field("channel_id", 16'(got.channel_id), 16'(want.channel_id));
					check_field("first_byte", 16'(got.first_byte), 16'(want.first_byte));
					check_field("header_byte", 16'(got.header_byte), 16'(want.header_byte));
					check_field("last_byte", 16'(got.last_byte), 16'(want.last_byte));
					check_field("overflow", 16'(got.overflow), 16'(want.overflow));
					if (want.overflow)
						n_ovf++;
					if (want.last_byte && want.frame_kind == KIND_BINARY)
						n_bin++;
				end
				n_checked++;
			end
			m_axis_tready <= !take_break();
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_LIMIT) begin
				$display("tb: timeout after %0d idle cycles", stall_cnt);
				$display("tb: done, errors");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end
	end

	initial begin : stim_proc
		logic [15:0] limits[9];
		int          per_phase;
		int          pick;
		int          len;
		ph = PH_HUNT;
		chan_q = 8'h00;
		left_q = 16'd0;
		tcount_q = 16'd0;
		tprog_q = 2'd0;
		max_len_q = MAX_TEXT_LEN_RST;

		// Directed: header extremes, zero length, terminator, cuts
		push_binary(8'hFF, 16'h0000);
		push_binary(8'h00, 16'h0001);
		push_byte(8'h41);
		push_byte(CR);
		push_byte(LF);
		push_byte(CR);
		push_byte(LF);
		push_cfg(16'd4);
		push_byte(8'h78);
		push_byte(8'h79);
		push_byte(8'h7A);
		push_byte(8'h77);
		// terminator landing on the very last allowed byte
		push_byte(CR);
		push_byte(LF);
		push_byte(CR);
		push_byte(LF);
		// a limit below the floor acts as the floor
		push_cfg(16'd0);
		push_byte(8'h61);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h64);

		// Random: mostly well-formed frames, some noise
		limits = '{16'hFFFF, 16'd16, 16'd4, 16'd7, 16'd300, 16'd2, 16'd4096, 16'd5, 16'd24};
		per_phase = (BYTE_GOAL - n_queued) / 9;
		foreach (limits[k]) begin
			push_cfg(limits[k]);
			while (n_queued < 21 + per_phase * (k + 1)) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					len = $urandom_range(99);
					if (len < 70)
						len = $urandom_range(12);
					else if (len < 92)
						len = $urandom_range(13, 64);
					else
						len = $urandom_range(250, 270);
					push_binary(8'($urandom_range(255)), 16'(len));
				end else if (pick < 82) begin
					push_text($urandom_range(1, 24), $urandom_range(99) < 80);
				end else begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++)
						push_byte(rand_byte());
				end
			end
		end
		push_cfg(MAX_TEXT_LEN_RST);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain, then give the pipeline time to show any stray beat
		while (stim_q.size() != 0 || s_axis_tvalid || cfg_valid || tag_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tag_q.size() != 0)
			flag_error($sformatf("%0d tagged bytes never arrived", tag_q.size()));

		$display("tb: %0d bytes sent, %0d checked, %0d register writes", n_sent, n_checked,
			n_cfg);
		$display("tb: %0d interleaved frames closed, %0d text cuts at the limit", n_bin,
			n_ovf);
		if (n_err == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
